// ===== src/vdi_pkg.sv =====
package vdi_pkg;

  localparam int NUM_COMP   = 8;
  localparam int IN_COORD_W = 32;
  localparam int IDX_OUT_W  = 10;
  localparam int TOL_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int S_DATA_W   = NUM_COMP * IN_COORD_W;
  localparam int M_DATA_W   = 16;
  localparam int M_USER_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_USES_UVS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

  // Number of leading components that are always compared (position and normal).
  localparam int NUM_BASE_COMP = 6;

  // Bit positions inside m_tuser.
  localparam int UBIT_WAS_NEW    = 0;
  localparam int UBIT_TABLE_FULL = 1;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] vertex_index;
    logic                 was_new;
    logic                 table_full;
  } result_t;

endpackage

// ===== src/vertex_dedup_indexer_unit.sv =====
// Vertex welding index builder. Each input transaction is one face corner
// (position, normal and UV pair, signed Q16.16). The corner is compared with
// the stored unique vertices from entry 0 upward, one entry per clock through
// a single registered table read port and an eight-lane tolerance compare.
// The first entry whose compared components all differ by strictly less than
// the tolerance gives the index; otherwise the corner is appended. A match at
// entry e ends the search before later entries are read; with no match, every
// stored entry is compared first. s_tready is low while an item is being
// processed. A finished result waits in an output register, so the next corner
// can be accepted before it is taken. start_mesh empties the table before its
// corner is handled. When the table is full and nothing matches, table_full is
// set, vertex_index is 0 and nothing is stored. The user must make
// configuration writes only while the block is idle, unenforced by the block.
module vertex_dedup_indexer_unit
  import vdi_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOL_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v (32 bits each).
  input  logic [S_DATA_W-1:0]  s_tdata,
  // start_mesh.
  input  logic [0:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // vertex_index (10 bits), then zero fill.
  output logic [M_DATA_W-1:0]  m_tdata,
  // was_new, table_full.
  output logic [M_USER_W-1:0]  m_tuser
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int ROW_W  = NUM_COMP * COORD_BITS;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]           state;
  logic                 uses_uvs;
  logic [TOL_W-1:0]     tolerance;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     pend_idx;
  logic                 pend_valid;
  logic [ROW_W-1:0]     corner;
  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     mem [TABLE_DEPTH];
  result_t              res;
  result_t              res_next;
  result_t              out_res;
  logic                 out_valid;

  logic                 in_fire;
  logic                 hit;
  logic                 more;
  logic                 issue;
  logic                 decide;
  logic                 wr_en;
  logic                 out_free;
  logic [NUM_COMP-1:0]  near;
  logic [NUM_COMP-1:0]  lane_ok;
  logic [DIFF_W-1:0]    tol_ext;
  logic [DIFF_W-1:0]    tol_neg;
  logic [IDX_OUT_W+IDX_W-1:0] hit_idx_wide;
  logic [IDX_OUT_W+IDX_W-1:0] new_idx_wide;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  assign tol_ext = {{(DIFF_W - TOL_W){1'b0}}, tolerance};
  assign tol_neg = {DIFF_W{1'b0}} - tol_ext;

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
    logic signed [DIFF_W-1:0] a_ext;
    logic signed [DIFF_W-1:0] b_ext;
    logic signed [DIFF_W-1:0] diff;
    assign a_ext = {rd_row[k*COORD_BITS + COORD_BITS - 1], rd_row[k*COORD_BITS +: COORD_BITS]};
    assign b_ext = {corner[k*COORD_BITS + COORD_BITS - 1], corner[k*COORD_BITS +: COORD_BITS]};
    assign diff  = a_ext - b_ext;
    assign near[k] = (diff < $signed(tol_ext)) && (diff > $signed(tol_neg));
    if (k < NUM_BASE_COMP) begin : g_base
      assign lane_ok[k] = near[k];
    end else begin : g_uv
      assign lane_ok[k] = near[k] || !uses_uvs;
    end
  end

  assign hit    = (state == S_SEARCH) && pend_valid && (&lane_ok);
  assign more   = (rd_idx < count);
  assign issue  = (state == S_SEARCH) && !hit && more;
  assign decide = (state == S_SEARCH) && !hit && !more;
  assign wr_en  = decide && (count != DEPTH_CNT);

  assign hit_idx_wide = {{IDX_OUT_W{1'b0}}, pend_idx};
  assign new_idx_wide = {{IDX_OUT_W{1'b0}}, count[IDX_W-1:0]};

  always_comb begin
    res_next = res;
    if (hit) begin
      res_next.vertex_index = hit_idx_wide[IDX_OUT_W-1:0];
      res_next.was_new      = 1'b0;
      res_next.table_full   = 1'b0;
    end else if (decide) begin
      if (wr_en) begin
        res_next.vertex_index = new_idx_wide[IDX_OUT_W-1:0];
        res_next.was_new      = 1'b1;
        res_next.table_full   = 1'b0;
      end else begin
        res_next.vertex_index = '0;
        res_next.was_new      = 1'b0;
        res_next.table_full   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_row <= mem[rd_idx[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= corner;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (issue) begin
      pend_idx <= rd_idx[IDX_W-1:0];
    end
    if (in_fire) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        corner[k*COORD_BITS +: COORD_BITS] <= s_tdata[k*IN_COORD_W +: COORD_BITS];
      end
    end
    if ((state == S_DONE) && out_free) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      uses_uvs   <= 1'b0;
      tolerance  <= TOL_RESET;
      count      <= '0;
      rd_idx     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_USES_UVS:  uses_uvs  <= cfg_data[0];
          REG_TOLERANCE: tolerance <= cfg_data;
          default:       ;
        endcase
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser[0]) begin
              count <= '0;
            end
            rd_idx     <= '0;
            pend_valid <= 1'b0;
            state      <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          pend_valid <= issue;
          if (issue) begin
            rd_idx <= rd_idx + CNT_ONE;
          end
          if (wr_en) begin
            count <= count + CNT_ONE;
          end
          if (hit || decide) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - IDX_OUT_W){1'b0}}, out_res.vertex_index};
  always_comb begin
    m_tuser                  = '0;
    m_tuser[UBIT_WAS_NEW]    = out_res.was_new;
    m_tuser[UBIT_TABLE_FULL] = out_res.table_full;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("entry count exceeds table depth");

  a_append_step: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + CNT_ONE))
    else $error("append did not advance the entry count by one");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[UBIT_WAS_NEW] && m_tuser[UBIT_TABLE_FULL]))
    else $error("result flagged both new and full");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[UBIT_TABLE_FULL]) |-> (m_tdata == '0))
    else $error("full result carries a nonzero index");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (rd_idx < DEPTH_CNT))
    else $error("table read beyond its depth");
`endif

endmodule
